[rtl/core/deq_pkg.sv]
// Shared types and defaults for the double-ended queue.
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ACT_PUSH_BACK  = 2'd0,
		ACT_PUSH_FRONT = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	// One-hot update command broadcast to every cell; all low when nothing changes.
	typedef struct packed {
		logic push_back;
		logic push_front;
		logic pop_front;
		logic pop_back;
	} cell_ctrl_t;

endpackage

[rtl/core/double_ended_queue_top.sv]
// Double-ended queue built as a row of shifting storage cells.
// A request is taken at a clock edge with start high and busy low; its result
// (ok, data_out, count_after) is registered at that edge and shown while done
// is high for a single cycle; the receiver cannot hold it off. Entries sit
// packed in the cell row with the front in cell 0, so pushes and pops at the
// front shift the whole row together and pushes and pops at the back touch
// only the one cell at the end of the occupied run. The back word reaches the
// output through a registered line that moves it one cell per cycle toward
// cell 0. Busy is loaded with the entry count after each request and counts
// down to zero; requests are taken only while it is low, so they can follow
// back to back with the queue empty. No clearing pass is needed after reset.
module double_ended_queue_top import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  logic [DATA_WIDTH-1:0] data_in,
	output logic                  done,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [CNT_W-1:0]      count_after
);

	action_t               act;
	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  ok_c;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;
	logic [CNT_W-1:0]      settle_q;
	logic                  done_q;
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [DATA_WIDTH-1:0] pop_word;

	logic [DEPTH-1:0]                 valid;
	logic [DEPTH-1:0][DATA_WIDTH-1:0] data;
	logic [DEPTH-1:0][DATA_WIDTH-1:0] tail;

	assign act    = action_t'(action);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign busy   = (settle_q != '0);
	assign accept = start & ~busy;

	always_comb begin
		unique case (act)
			ACT_PUSH_BACK, ACT_PUSH_FRONT: ok_c = ~full;
			ACT_POP_FRONT, ACT_POP_BACK:   ok_c = ~empty;
			default:                       ok_c = 1'b0;
		endcase
	end

	always_comb begin
		ctrl            = '0;
		ctrl.push_back  = accept & ok_c & (act == ACT_PUSH_BACK);
		ctrl.push_front = accept & ok_c & (act == ACT_PUSH_FRONT);
		ctrl.pop_front  = accept & ok_c & (act == ACT_POP_FRONT);
		ctrl.pop_back   = accept & ok_c & (act == ACT_POP_BACK);
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.push_back || ctrl.push_front) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.pop_front || ctrl.pop_back) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		pop_word = '0;
		if (ctrl.pop_front) begin
			pop_word = data[0];
		end else if (ctrl.pop_back) begin
			pop_word = tail[0];
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                  lv;
			logic [DATA_WIDTH-1:0] ld;
			logic                  rv;
			logic [DATA_WIDTH-1:0] rd;
			logic [DATA_WIDTH-1:0] ti;

			if (i == 0) begin : g_first
				assign lv = 1'b1;
				assign ld = data_in;
			end else begin : g_inner_l
				assign lv = valid[i-1];
				assign ld = data[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign rv = 1'b0;
				assign rd = '0;
				assign ti = '0;
			end else begin : g_inner_r
				assign rv = valid[i+1];
				assign rd = data[i+1];
				assign ti = tail[i+1];
			end

			deq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.word       (data_in),
				.left_valid (lv),
				.left_data  (ld),
				.right_valid(rv),
				.right_data (rd),
				.tail_in    (ti),
				.valid      (valid[i]),
				.data       (data[i]),
				.tail       (tail[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			settle_q <= '0;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= count_next;
				settle_q <= count_next;
				ok_q     <= ok_c;
			end else if (busy) begin
				settle_q <= settle_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= pop_word;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign data_out    = data_out_q;
	assign count_after = count_q;

	// occupied cells always match the entry count
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(count_q))
		else $error("cell occupancy differs from entry count");

	// entries stay packed toward cell 0
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid & (valid + DEPTH'(1))) == '0)
		else $error("gap in the occupied cell row");

	// a result follows only an accepted request
	a_done_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without request");

	// a refused request leaves the count alone
	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ok_c) |=> (count_q == $past(count_q)))
		else $error("refused request changed the count");

	// the settle time never exceeds the count it was loaded from
	a_settle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q <= count_q)
		else $error("settle counter beyond entry count");

endmodule

[rtl/core/deq_cell.sv]
// One storage cell of the queue row, with its stage of the back-entry line.
module deq_cell import deq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  right_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [DATA_WIDTH-1:0] tail_in,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tail
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] tail_q;
	logic                  is_back;
	logic                  is_slot;

	// back entry: occupied with an empty right neighbor; slot: first empty cell
	assign is_back = valid_q & ~right_valid;
	assign is_slot = ~valid_q & left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctrl.push_front) begin
				valid_q <= left_valid;
			end else if (ctrl.pop_front) begin
				valid_q <= right_valid;
			end else if (ctrl.push_back && is_slot) begin
				valid_q <= 1'b1;
			end else if (ctrl.pop_back && is_back) begin
				valid_q <= 1'b0;
			end else begin
				valid_q <= valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end else if (ctrl.push_back && is_slot) begin
			data_q <= word;
		end else begin
			data_q <= data_q;
		end
	end

	// back word travels one cell toward the front each cycle
	always_ff @(posedge clk) begin
		tail_q <= is_back ? data_q : tail_in;
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign tail  = tail_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the double-ended queue: directed and random operations with a scoreboard.
`timescale 1ns / 100ps

module testbench;
	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int DW    = DATA_WIDTH_DEF;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int PW    = $clog2(DEPTH);

	typedef struct {
		logic          ok;
		logic [DW-1:0] word;
		logic [CW-1:0] held;
	} reply_t;

	// Tracks deque contents and the replies owed for accepted requests.
	class deque_tracker;
		logic [DW-1:0] store [DEPTH];
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [CW-1:0] held;
		reply_t        owed[$];
		int            mismatches;

		function new();
			head = '0;
			tail = '0;
			held = '0;
			mismatches = 0;
		endfunction

		function logic [PW-1:0] fwd(logic [PW-1:0] p);
			return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
		endfunction

		function logic [PW-1:0] bwd(logic [PW-1:0] p);
			return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_request(action_t act, logic [DW-1:0] word);
			reply_t r;
			r.ok = 1'b0;
			r.word = '0;
			case (act)
				ACT_PUSH_BACK: begin
					if (held < CW'(DEPTH)) begin
						store[tail] = word;
						tail = fwd(tail);
						held++;
						r.ok = 1'b1;
					end
				end
				ACT_PUSH_FRONT: begin
					if (held < CW'(DEPTH)) begin
						head = bwd(head);
						store[head] = word;
						held++;
						r.ok = 1'b1;
					end
				end
				ACT_POP_FRONT: begin
					if (held != '0) begin
						r.word = store[head];
						head = fwd(head);
						held--;
						r.ok = 1'b1;
					end
				end
				default: begin
					if (held != '0) begin
						tail = bwd(tail);
						r.word = store[tail];
						held--;
						r.ok = 1'b1;
					end
				end
			endcase
			r.held = held;
			owed.push_back(r);
		endfunction

		function void check_result(logic ok, logic [DW-1:0] word, logic [CW-1:0] cnt);
			reply_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request pending: ok=%0b data=%h count=%0d",
						$realtime, ok, word, cnt);
				return;
			end
			e = owed.pop_front();
			if (ok !== e.ok || word !== e.word || cnt !== e.held) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: exp ok=%0b data=%h count=%0d, got ok=%0b data=%h count=%0d",
						$realtime, e.ok, e.word, e.held, ok, word, cnt);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	action_t       action;
	logic [DW-1:0] data_in;
	logic          done;
	logic          ok;
	logic [DW-1:0] data_out;
	logic [CW-1:0] count_after;

	deque_tracker tracker;
	bit           no_idle;

	double_ended_queue_top #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.data_in(data_in),
		.done(done),
		.ok(ok),
		.data_out(data_out),
		.count_after(count_after)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(ok, data_out, count_after);
	end

	// Issue one request; start stays high when the next one follows back to back.
	task automatic send(input action_t act, input logic [DW-1:0] word);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		data_in <= word;
		do @(posedge clk); while (busy);
		tracker.note_request(act, word);
	endtask

	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return DW'($urandom);
		endcase
	endfunction

	initial begin
		int      push_pct;
		action_t act;
		tracker = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_PUSH_BACK;
		data_in = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, extreme words, fill to full, refused pushes
		send(ACT_POP_FRONT, '1);
		send(ACT_POP_BACK, '1);
		send(ACT_PUSH_BACK, '0);
		send(ACT_PUSH_FRONT, '1);
		send(ACT_POP_BACK, '1);
		send(ACT_POP_FRONT, '0);
		for (int i = 0; i < DEPTH; i++)
			send(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, i[1] ? '1 : DW'(i));
		send(ACT_PUSH_BACK, 32'hA5A5_5A5A);
		send(ACT_PUSH_FRONT, 32'h5A5A_A5A5);

		// random: alternate push-heavy and pop-heavy stretches to hit full and empty often
		push_pct = 30;
		for (int i = 0; i < 400; i++) begin
			if (i % 30 == 0)
				push_pct = 100 - push_pct;
			no_idle = (i >= 150 && i < 220);
			if (i == 100) begin
				start <= 1'b0;
				do @(posedge clk); while (tracker.pending() != 0);
			end
			if ($urandom_range(0, 99) < push_pct)
				act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			else
				act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
			send(act, pick_word());
		end
		start <= 1'b0;

		do @(posedge clk); while (tracker.pending() != 0);
		repeat (DEPTH + 4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
